// ----- rtl/core/rycp_pkg.sv -----
// Shared types and constants for the RGB to YCbCr converter with edge padding.
// Used by every module under rtl/core; depends on nothing.
package rycp_pkg;

  localparam int PIX_W  = 8;
  localparam int POS_W  = 12;
  localparam int DIM_W  = 13;
  localparam int ACC_W  = 26;
  localparam int FRAC_W = 16;
  localparam int CFG_IDX_W = 2;

  // Largest image dimension the position counters can address.
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
  localparam logic [DIM_W-1:0] RESET_DIM = 13'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // Q16 coefficients: luma rounded half up from the published values; each chroma set sums to zero.
  localparam logic signed [ACC_W-1:0] COEF_Y_R  =  26'sd19595;
  localparam logic signed [ACC_W-1:0] COEF_Y_G  =  26'sd38470;
  localparam logic signed [ACC_W-1:0] COEF_Y_B  =  26'sd7471;
  localparam logic signed [ACC_W-1:0] COEF_CB_R = -26'sd11056;
  localparam logic signed [ACC_W-1:0] COEF_CB_G = -26'sd21712;
  localparam logic signed [ACC_W-1:0] COEF_CB_B =  26'sd32768;
  localparam logic signed [ACC_W-1:0] COEF_CR_R =  26'sd32768;
  localparam logic signed [ACC_W-1:0] COEF_CR_G = -26'sd27440;
  localparam logic signed [ACC_W-1:0] COEF_CR_B = -26'sd5328;
  localparam logic signed [ACC_W-1:0] CHROMA_OFS = 26'sd8388608;

  // Rectangle of padded positions that one input pixel covers.
  typedef struct packed {
    logic [POS_W-1:0] row_first;
    logic [POS_W-1:0] col_first;
    logic [POS_W-1:0] row_last;
    logic [POS_W-1:0] col_last;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
  } ycc_t;

endpackage

// ----- rtl/core/rycp_pos.sv -----
// Image size registers and raster position counters.
// Produces the padded rectangle for the next pixel; depends on rycp_pkg.
module rycp_pos (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rycp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rycp_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           advance,
  output rycp_pkg::job_t                 job
);
  import rycp_pkg::*;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] col_count;
  logic [DIM_W-1:0] sat_data;
  logic [DIM_W-1:0] row_inc;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] pad_h_last;
  logic [DIM_W-1:0] pad_w_last;

  always_comb begin
    if (cfg_data == '0) begin
      sat_data = DIM_W'(1);
    end else if (cfg_data > MAX_DIM) begin
      sat_data = MAX_DIM;
    end else begin
      sat_data = cfg_data;
    end
  end

  assign row_inc = {1'b0, row_count} + DIM_W'(1);
  assign col_inc = {1'b0, col_count} + DIM_W'(1);
  // Last padded row and column: round up to a multiple of 8, minus one.
  assign pad_h_last = ((image_height + DIM_W'(7)) & ~DIM_W'(7)) - DIM_W'(1);
  assign pad_w_last = ((image_width + DIM_W'(7)) & ~DIM_W'(7)) - DIM_W'(1);

  always_comb begin
    job.row_first = row_count;
    job.col_first = col_count;
    job.row_last  = (row_inc == image_height) ? pad_h_last[POS_W-1:0] : row_count;
    job.col_last  = (col_inc == image_width) ? pad_w_last[POS_W-1:0] : col_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_DIM;
      image_height <= RESET_DIM;
      row_count    <= '0;
      col_count    <= '0;
    end else if (cfg_write && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
      if (cfg_index == CFG_WIDTH) begin
        image_width <= sat_data;
      end else begin
        image_height <= sat_data;
      end
      row_count <= '0;
      col_count <= '0;
    end else if (advance) begin
      if (col_inc >= image_width) begin
        col_count <= '0;
        row_count <= (row_inc >= image_height) ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_count <= col_inc[POS_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/core/rycp_convert.sv -----
// Combinational JFIF RGB to YCbCr conversion with Q16 constant coefficients.
// Floors and clamps each channel to 0..255; depends on rycp_pkg.
module rycp_convert (
  input  logic [rycp_pkg::PIX_W-1:0] red,
  input  logic [rycp_pkg::PIX_W-1:0] green,
  input  logic [rycp_pkg::PIX_W-1:0] blue,
  output rycp_pkg::ycc_t             ycc
);
  import rycp_pkg::*;

  logic signed [ACC_W-1:0] r_s;
  logic signed [ACC_W-1:0] g_s;
  logic signed [ACC_W-1:0] b_s;
  logic signed [ACC_W-1:0] y_acc;
  logic signed [ACC_W-1:0] cb_acc;
  logic signed [ACC_W-1:0] cr_acc;

  function automatic logic [PIX_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (acc[ACC_W-2:FRAC_W] > (ACC_W-1-FRAC_W)'(255)) begin
      res = '1;
    end else begin
      res = acc[FRAC_W+PIX_W-1:FRAC_W];
    end
    return res;
  endfunction

  assign r_s = $signed({(ACC_W-PIX_W)'(0), red});
  assign g_s = $signed({(ACC_W-PIX_W)'(0), green});
  assign b_s = $signed({(ACC_W-PIX_W)'(0), blue});

  assign y_acc  = COEF_Y_R * r_s + COEF_Y_G * g_s + COEF_Y_B * b_s;
  assign cb_acc = COEF_CB_R * r_s + COEF_CB_G * g_s + COEF_CB_B * b_s + CHROMA_OFS;
  assign cr_acc = COEF_CR_R * r_s + COEF_CR_G * g_s + COEF_CR_B * b_s + CHROMA_OFS;

  always_comb begin
    ycc.luma        = finish(y_acc);
    ycc.chroma_blue = finish(cb_acc);
    ycc.chroma_red  = finish(cr_acc);
  end

endmodule

// ----- rtl/core/rycp_expand.sv -----
// Result register that walks the padded rectangle of one pixel, one result
// per transfer, in raster order. Depends on rycp_pkg.
module rycp_expand (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  rycp_pkg::job_t             job_in,
  input  rycp_pkg::ycc_t             ycc_in,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rycp_pkg::POS_W-1:0] out_row,
  output logic [rycp_pkg::POS_W-1:0] out_col,
  output logic [rycp_pkg::PIX_W-1:0] luma,
  output logic [rycp_pkg::PIX_W-1:0] chroma_blue,
  output logic [rycp_pkg::PIX_W-1:0] chroma_red,
  output logic                       run_last
);
  import rycp_pkg::*;

  job_t             job;
  ycc_t             ycc;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic             busy;
  logic             row_done;
  logic             xfer;

  assign row_done = (col == job.col_last);
  assign run_last = row_done && (row == job.row_last);
  assign xfer     = busy && !out_stall;
  // The register can take the next pixel once the final result is transferred.
  assign free     = !busy || (xfer && run_last);

  assign out_valid   = busy;
  assign out_row     = row;
  assign out_col     = col;
  assign luma        = ycc.luma;
  assign chroma_blue = ycc.chroma_blue;
  assign chroma_red  = ycc.chroma_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (free) begin
      busy <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      job <= job_in;
      ycc <= ycc_in;
      row <= job_in.row_first;
      col <= job_in.col_first;
    end else if (xfer && !run_last) begin
      if (row_done) begin
        col <= job.col_first;
        row <= row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/rgb_to_ycbcr_edge_pad.sv -----
// Streaming JFIF RGB to YCbCr converter that pads the image to 8x8 blocks
// by replicating the right and bottom edges. Depends on rycp_pkg,
// rycp_pos, rycp_convert and rycp_expand.
//
// Pixels enter in raster order, one per transfer; a pixel normally gives one
// result, a pixel in the last column or row gives its copies over the padded
// positions (up to 64 results), and run_last marks the final one. A pixel
// passes through the input register and then the result register. While
// out_stall is low, throughput is one result per cycle: an interior pixel
// can be taken every cycle, while an edge pixel holds the result register
// until its last result is transferred, as the output register emits one
// position per cycle. A write to the width or height register restarts the
// frame at row 0, column 0; a size of 0 acts as 1, one above 4096 as 4096.
module rgb_to_ycbcr_edge_pad (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rycp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rycp_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rycp_pkg::PIX_W-1:0]     red,
  input  logic [rycp_pkg::PIX_W-1:0]     green,
  input  logic [rycp_pkg::PIX_W-1:0]     blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rycp_pkg::POS_W-1:0]     out_row,
  output logic [rycp_pkg::POS_W-1:0]     out_col,
  output logic [rycp_pkg::PIX_W-1:0]     luma,
  output logic [rycp_pkg::PIX_W-1:0]     chroma_blue,
  output logic [rycp_pkg::PIX_W-1:0]     chroma_red,
  output logic                           run_last
);
  import rycp_pkg::*;

  job_t             next_job;
  job_t             job;
  ycc_t             ycc;
  logic [PIX_W-1:0] red_q;
  logic [PIX_W-1:0] green_q;
  logic [PIX_W-1:0] blue_q;
  logic             held;
  logic             free;
  logic             load;
  logic             in_xfer;

  assign load     = held && free;
  assign in_stall = held && !free;
  assign in_xfer  = in_valid && !in_stall;

  rycp_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_xfer),
    .job       (next_job)
  );

  // Input register: the pixel and its padded rectangle.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_xfer) begin
      held <= 1'b1;
    end else if (load) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      job     <= next_job;
    end
  end

  rycp_convert u_convert (
    .red   (red_q),
    .green (green_q),
    .blue  (blue_q),
    .ycc   (ycc)
  );

  rycp_expand u_expand (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .job_in      (job),
    .ycc_in      (ycc),
    .free        (free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_col     (out_col),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .run_last    (run_last)
  );

endmodule
